>>> sv/wrr_pkg.sv
// ----------------------------------------------------------------------------
// wrr_pkg
// Shared types and codes of the weighted round-robin scheduler.
// ----------------------------------------------------------------------------
package wrr_pkg;

    // request function codes as they arrive on the input channel
    localparam logic [2:0] FUNC_CREATE = 3'd0;
    localparam logic [2:0] FUNC_WAKE   = 3'd1;
    localparam logic [2:0] FUNC_TICK   = 3'd2;
    localparam logic [2:0] FUNC_SETPRI = 3'd3;
    localparam logic [2:0] FUNC_LEAVE  = 3'd4;

    // leave reasons
    localparam logic [2:0] LEAVE_SLEEP = 3'd0;
    localparam logic [2:0] LEAVE_PIPE  = 3'd1;
    localparam logic [2:0] LEAVE_WAIT  = 3'd2;
    localparam logic [2:0] LEAVE_ZOMB  = 3'd3;
    localparam logic [2:0] LEAVE_YIELD = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PRIO_MIN = 2'd0;
    localparam logic [1:0] CFG_PRIO_MAX = 2'd1;
    localparam logic [1:0] CFG_PRIO_DEF = 2'd2;

    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        ST_UNUSED    = 3'd0,
        ST_RUNNABLE  = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_SLEEPING  = 3'd3,
        ST_WAIT_PIPE = 3'd4,
        ST_WAITING   = 3'd5,
        ST_ZOMBIE    = 3'd6
    } slot_st_t;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_WAKE,
        OP_TICK,
        OP_SETPRI,
        OP_LEAVE,
        OP_BAD
    } op_t;

    // classified request handed from the front end to the back end
    typedef struct packed {
        op_t         op;
        logic [3:0]  target;
        logic        tgt_ok;
        logic [7:0]  prio;
        logic [63:0] now;
        logic [15:0] mask;
        slot_st_t    leave_st;
        logic        leave_ok;
        logic [63:0] wake_at;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic       switched;
        logic       idle;
    } res_t;

endpackage

>>> sv/wrr_ram.sv
// ----------------------------------------------------------------------------
// wrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/wrr_queue.sv
// ----------------------------------------------------------------------------
// wrr_queue
// Two-entry command queue between the request decoder and the engine.
// ----------------------------------------------------------------------------
module wrr_queue
    import wrr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic valid
);

    localparam int AW = $clog2(QDEPTH);

    cmd_t            mem_reg [QDEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= din;
                wr_ptr_reg          <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign full  = (cnt_reg == (AW+1)'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

endmodule

>>> sv/wrr_front.sv
// ----------------------------------------------------------------------------
// wrr_front
// Request decoder: accepts words, classifies them and clamps priorities.
// ----------------------------------------------------------------------------
module wrr_front
    import wrr_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic [3:0]         s_target_slot,
    input  logic signed [15:0] s_new_priority,
    input  logic [63:0]        s_now_time,
    input  logic [15:0]        s_pipe_ready_mask,
    input  logic [2:0]         s_leave_state,
    input  logic [63:0]        s_wake_at,
    input  logic [7:0]         prio_min,
    input  logic [7:0]         prio_max,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    logic signed [15:0] pmin_s;
    logic signed [15:0] pmax_s;
    logic signed [15:0] p_lo;
    logic [7:0]         p_clamped;

    // raise to min first, then lower to max
    always_comb begin
        pmin_s    = signed'({8'd0, prio_min});
        pmax_s    = signed'({8'd0, prio_max});
        p_lo      = (s_new_priority < pmin_s) ? pmin_s : s_new_priority;
        p_clamped = (p_lo > pmax_s) ? prio_max : p_lo[7:0];
    end

    always_comb begin
        q_cmd.target   = s_target_slot;
        q_cmd.tgt_ok   = (32'(s_target_slot) < SLOTS);
        q_cmd.prio     = p_clamped;
        q_cmd.now      = s_now_time;
        q_cmd.mask     = s_pipe_ready_mask;
        q_cmd.wake_at  = s_wake_at;
        q_cmd.leave_ok = (s_leave_state <= LEAVE_YIELD);

        case (s_func)
            FUNC_CREATE: q_cmd.op = OP_CREATE;
            FUNC_WAKE:   q_cmd.op = OP_WAKE;
            FUNC_TICK:   q_cmd.op = OP_TICK;
            FUNC_SETPRI: q_cmd.op = OP_SETPRI;
            FUNC_LEAVE:  q_cmd.op = OP_LEAVE;
            default:     q_cmd.op = OP_BAD;
        endcase

        case (s_leave_state)
            LEAVE_SLEEP: q_cmd.leave_st = ST_SLEEPING;
            LEAVE_PIPE:  q_cmd.leave_st = ST_WAIT_PIPE;
            LEAVE_WAIT:  q_cmd.leave_st = ST_WAITING;
            LEAVE_ZOMB:  q_cmd.leave_st = ST_ZOMBIE;
            default:     q_cmd.leave_st = ST_RUNNABLE;
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

>>> sv/wrr_back.sv
// ----------------------------------------------------------------------------
// wrr_back
// Scheduling engine: slot table, round-robin pick, wake sweep and result word.
// ----------------------------------------------------------------------------
module wrr_back
    import wrr_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] prio_def,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    output logic       res_vld,
    output res_t       res,
    input  logic       res_ready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXEC,
        B_WAKE,
        B_SRCH,
        B_PICK
    } bst_t;

    bst_t            fsm_reg;
    cmd_t            cmd_reg;
    res_t            res_reg;
    logic            res_vld_reg;

    slot_st_t        st_reg     [SLOTS];
    logic [7:0]      prio_reg   [SLOTS];
    logic [7:0]      slice_reg  [SLOTS];
    logic [31:0]     ticks_reg  [SLOTS];
    logic [SLOTS-1:0] dlv_reg;
    logic            cur_vld_reg;
    logic [SW-1:0]   cur_reg;

    logic [SW:0]     wk_cnt_reg;
    logic            chk_vld_reg;
    logic [SW-1:0]   chk_idx_reg;
    logic [SLOTS-1:0] rot_reg;
    logic [SLOTS-1:0] rot_next;

    logic [SLOTS-1:0]   free_vec;
    logic [SLOTS-1:0]   run_vec;
    logic               free_any;
    logic [SW-1:0]      free_idx;
    logic [SW-1:0]      start;
    logic [SW:0]        shamt;
    logic [2*SLOTS-1:0] dbl;
    logic               pick_any;
    logic [SW-1:0]      pick_off;
    logic [SW+1:0]      pick_sum;
    logic [SW-1:0]      pick_idx;
    logic               cur_run;
    logic [SLOTS+15:0]  mask_ext;
    logic [SW-1:0]      tgt_idx;
    logic               ram_we;
    logic [63:0]        ram_rdata;
    logic [63:0]        dl_val;

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            free_vec[i] = (st_reg[i] == ST_UNUSED);
            run_vec[i]  = (st_reg[i] == ST_RUNNABLE);
            if (free_vec[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end

        // round-robin: rotate so the slot after the current one lands at bit 0
        start    = cur_vld_reg ? cur_reg : '0;
        shamt    = {1'b0, start} + 1'b1;
        dbl      = {run_vec, run_vec} >> shamt;
        rot_next = dbl[SLOTS-1:0];

        pick_any = 1'b0;
        pick_off = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (rot_reg[i]) begin
                pick_any = 1'b1;
                pick_off = SW'(i);
            end
        end
        pick_sum = (SW+2)'(start) + (SW+2)'(1) + (SW+2)'(pick_off);
        pick_idx = (pick_sum >= (SW+2)'(SLOTS)) ? SW'(pick_sum - (SW+2)'(SLOTS))
                                                : SW'(pick_sum);

        cur_run  = cur_vld_reg && (st_reg[cur_reg] == ST_RUNNING);
        mask_ext = {{SLOTS{1'b0}}, cmd_reg.mask};
        tgt_idx  = SW'(cmd_reg.target);
        dl_val   = dlv_reg[chk_idx_reg] ? ram_rdata : 64'd0;
    end

    assign ram_we = (fsm_reg == B_EXEC) && (cmd_reg.op == OP_LEAVE) && cur_run
                    && cmd_reg.leave_ok && (cmd_reg.leave_st == ST_SLEEPING);

    wrr_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS)
    ) u_deadline (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cur_reg),
        .wdata (cmd_reg.wake_at),
        .raddr (SW'(wk_cnt_reg)),
        .rdata (ram_rdata)
    );

    assign q_pop = (fsm_reg == B_IDLE) && q_valid && !res_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= B_IDLE;
            res_vld_reg <= 1'b0;
            cur_vld_reg <= 1'b0;
            dlv_reg     <= '0;
            chk_vld_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                st_reg[i] <= ST_UNUSED;
            end
        end else begin
            if (res_vld_reg && res_ready) begin
                res_vld_reg <= 1'b0;
            end

            case (fsm_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        cmd_reg <= q_cmd;
                        fsm_reg <= B_EXEC;
                    end
                end

                B_EXEC: begin
                    fsm_reg <= B_IDLE;
                    case (cmd_reg.op)
                        OP_CREATE: begin
                            res_vld_reg <= 1'b1;
                            if (free_any) begin
                                st_reg[free_idx]    <= ST_RUNNABLE;
                                prio_reg[free_idx]  <= prio_def;
                                slice_reg[free_idx] <= prio_def;
                                ticks_reg[free_idx] <= '0;
                                dlv_reg[free_idx]   <= 1'b0;
                                res_reg <= '{STATUS_DONE, 4'(free_idx), 1'b0, 1'b0};
                            end else begin
                                res_reg <= '{STATUS_FULL, 4'd0, 1'b0, 1'b0};
                            end
                        end

                        OP_WAKE: begin
                            // pipe waiters wake at once, sleepers in the sweep
                            for (int i = 0; i < SLOTS; i++) begin
                                if (st_reg[i] == ST_WAIT_PIPE && mask_ext[i]) begin
                                    st_reg[i] <= ST_RUNNABLE;
                                end
                            end
                            wk_cnt_reg  <= '0;
                            chk_vld_reg <= 1'b0;
                            fsm_reg     <= B_WAKE;
                        end

                        OP_TICK: begin
                            if (cur_run) begin
                                ticks_reg[cur_reg] <= ticks_reg[cur_reg] + 32'd1;
                                if (slice_reg[cur_reg] > 8'd1) begin
                                    slice_reg[cur_reg] <= slice_reg[cur_reg] - 8'd1;
                                    res_vld_reg <= 1'b1;
                                    res_reg <= '{STATUS_DONE, 4'(cur_reg), 1'b0, 1'b0};
                                end else begin
                                    slice_reg[cur_reg] <= 8'd0;
                                    st_reg[cur_reg]    <= ST_RUNNABLE;
                                    fsm_reg            <= B_SRCH;
                                end
                            end else begin
                                fsm_reg <= B_SRCH;
                            end
                        end

                        OP_SETPRI: begin
                            res_vld_reg <= 1'b1;
                            if (cmd_reg.tgt_ok && st_reg[tgt_idx] != ST_UNUSED) begin
                                prio_reg[tgt_idx] <= cmd_reg.prio;
                                res_reg <= '{STATUS_DONE, cmd_reg.target, 1'b0, 1'b0};
                            end else begin
                                res_reg <= '{STATUS_IGNORED, 4'd0, 1'b0, 1'b0};
                            end
                        end

                        OP_LEAVE: begin
                            if (cur_run && cmd_reg.leave_ok) begin
                                st_reg[cur_reg] <= cmd_reg.leave_st;
                                if (cmd_reg.leave_st == ST_SLEEPING) begin
                                    dlv_reg[cur_reg] <= 1'b1;
                                end
                                fsm_reg <= B_SRCH;
                            end else begin
                                res_vld_reg <= 1'b1;
                                res_reg <= '{STATUS_IGNORED, 4'd0, 1'b0, 1'b0};
                            end
                        end

                        default: begin
                            res_vld_reg <= 1'b1;
                            res_reg <= '{STATUS_IGNORED, 4'd0, 1'b0, 1'b0};
                        end
                    endcase
                end

                B_WAKE: begin
                    // one deadline read issued per cycle, compared in the following cycle
                    if (wk_cnt_reg != (SW+1)'(SLOTS)) begin
                        wk_cnt_reg  <= wk_cnt_reg + 1'b1;
                        chk_vld_reg <= 1'b1;
                        chk_idx_reg <= SW'(wk_cnt_reg);
                    end else begin
                        chk_vld_reg <= 1'b0;
                    end
                    if (chk_vld_reg && st_reg[chk_idx_reg] == ST_SLEEPING
                        && cmd_reg.now >= dl_val) begin
                        st_reg[chk_idx_reg] <= ST_RUNNABLE;
                    end
                    if (wk_cnt_reg == (SW+1)'(SLOTS) && !chk_vld_reg) begin
                        res_vld_reg <= 1'b1;
                        res_reg     <= '{STATUS_DONE, 4'd0, 1'b0, 1'b0};
                        fsm_reg     <= B_IDLE;
                    end
                end

                B_SRCH: begin
                    rot_reg <= rot_next;
                    fsm_reg <= B_PICK;
                end

                B_PICK: begin
                    res_vld_reg <= 1'b1;
                    fsm_reg     <= B_IDLE;
                    if (pick_any) begin
                        st_reg[pick_idx]    <= ST_RUNNING;
                        slice_reg[pick_idx] <= prio_reg[pick_idx];
                        cur_reg             <= pick_idx;
                        cur_vld_reg         <= 1'b1;
                        res_reg <= '{STATUS_DONE, 4'(pick_idx),
                                     !(cur_vld_reg && cur_reg == pick_idx), 1'b0};
                    end else begin
                        cur_vld_reg <= 1'b0;
                        res_reg     <= '{STATUS_DONE, 4'd0, 1'b0, 1'b1};
                    end
                end

                default: begin
                    fsm_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

>>> sv/weighted_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// weighted_round_robin_scheduler
// Task scheduler over a slot table with round-robin selection and slices.
// ----------------------------------------------------------------------------
// Requests pass through a two-entry queue to a sequencer that handles one at
// a time and leaves its result word in an output register, so new requests
// are taken while a result waits. Create, set priority and rejected requests
// and a tick that keeps the task are done in the execute state; a tick or
// leave that schedules goes through state update, rotate and pick; a wake
// scan is bounded by the wake deadline memory, which has one read port and
// is swept one slot a cycle.
// The next request leaves the queue once the previous result is taken.
module weighted_round_robin_scheduler
    import wrr_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic [3:0]         s_target_slot,
    input  logic signed [15:0] s_new_priority,
    input  logic [63:0]        s_now_time,
    input  logic [15:0]        s_pipe_ready_mask,
    input  logic [2:0]         s_leave_state,
    input  logic [63:0]        s_wake_at,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [3:0]         m_chosen_slot,
    output logic               m_switched,
    output logic               m_idle
);

    logic [7:0] prio_min_reg;
    logic [7:0] prio_max_reg;
    logic [7:0] prio_def_reg;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_din;
    cmd_t q_dout;
    res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_min_reg <= 8'd1;
            prio_max_reg <= 8'd8;
            prio_def_reg <= 8'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PRIO_MIN: prio_min_reg <= cfg_wdata;
                CFG_PRIO_MAX: prio_max_reg <= cfg_wdata;
                CFG_PRIO_DEF: prio_def_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wrr_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_target_slot     (s_target_slot),
        .s_new_priority    (s_new_priority),
        .s_now_time        (s_now_time),
        .s_pipe_ready_mask (s_pipe_ready_mask),
        .s_leave_state     (s_leave_state),
        .s_wake_at         (s_wake_at),
        .prio_min          (prio_min_reg),
        .prio_max          (prio_max_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_cmd             (q_din)
    );

    wrr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .valid   (q_valid)
    );

    wrr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .prio_def  (prio_def_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_dout),
        .q_pop     (q_pop),
        .res_vld   (m_valid),
        .res       (res),
        .res_ready (m_ready)
    );

    assign m_status      = res.status;
    assign m_chosen_slot = res.slot;
    assign m_switched    = res.switched;
    assign m_idle        = res.idle;

`ifndef ASSERT_OFF
    // an empty search reports no slot and no switch
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle |-> m_chosen_slot == 4'd0 && !m_switched
                              && m_status == STATUS_DONE)
        else $error("idle result carries slot or switch");

    // rejected or full requests never schedule
    a_fail_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_DONE |-> !m_switched && !m_idle
                                               && m_chosen_slot == 4'd0)
        else $error("failed request reports scheduling");

    // the engine only takes a word the queue holds
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid && !m_valid)
        else $error("queue popped while empty or result pending");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted round-robin task scheduler.
// Requests go in over a valid/ready channel with random gaps. An in-bench
// scheduler model predicts each result word, and a sink with random stalls
// scores every word field by field. Phases run under several priority
// bounds, and one phase holds the sink off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
    import wrr_pkg::*;

    localparam int          SLOTS       = 16;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          PRINT_CAP   = 30;
    localparam logic [63:0] ALL_ONES    = '1;

    // codes the block rejects
    localparam logic [2:0] FUNC_BAD_LO  = 3'd5;
    localparam logic [2:0] FUNC_BAD_HI  = 3'd7;
    localparam logic [2:0] LEAVE_BAD_LO = 3'd5;
    localparam logic [2:0] LEAVE_BAD_HI = 3'd7;

    typedef struct {
        logic [2:0]         func;
        logic [3:0]         target;
        logic signed [15:0] new_pri;
        logic [63:0]        now;
        logic [15:0]        mask;
        logic [2:0]         leave;
        logic [63:0]        wake_at;
    } sched_req_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_func;
    logic [3:0]         s_target_slot;
    logic signed [15:0] s_new_priority;
    logic [63:0]        s_now_time;
    logic [15:0]        s_pipe_ready_mask;
    logic [2:0]         s_leave_state;
    logic [63:0]        s_wake_at;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [3:0]         m_chosen_slot;
    logic               m_switched;
    logic               m_idle;

    // scheduler model
    slot_st_t    tcb_state [SLOTS];
    logic [7:0]  tcb_prio  [SLOTS];
    logic [7:0]  tcb_slice [SLOTS];
    logic [31:0] tcb_ticks [SLOTS];
    logic [63:0] tcb_wake  [SLOTS];
    int unsigned running_slot;
    logic [7:0]  prio_floor;
    logic [7:0]  prio_ceil;
    logic [7:0]  prio_init;

    res_t        expected_words [$];
    int          mismatches  = 0;
    int unsigned cycle_count = 0;
    int          src_run     = 0;
    int          sink_run    = 0;
    int          hold_cycles = 0;
    bit          src_no_gaps = 1'b0;
    logic [63:0] model_now   = 64'd1000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    weighted_round_robin_scheduler #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_target_slot     (s_target_slot),
        .s_new_priority    (s_new_priority),
        .s_now_time        (s_now_time),
        .s_pipe_ready_mask (s_pipe_ready_mask),
        .s_leave_state     (s_leave_state),
        .s_wake_at         (s_wake_at),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_chosen_slot     (m_chosen_slot),
        .m_switched        (m_switched),
        .m_idle            (m_idle)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
    endtask

    // zero wait throughout a burst, which starts at random; otherwise a random wait that may be zero
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < SLOTS; i++) begin
            tcb_state[i] = ST_UNUSED;
            tcb_prio[i]  = '0;
            tcb_slice[i] = '0;
            tcb_ticks[i] = '0;
            tcb_wake[i]  = '0;
        end
        running_slot = SLOTS;
        prio_floor   = 8'd1;
        prio_ceil    = 8'd8;
        prio_init    = 8'd4;
    endfunction

    // round-robin pick starting after the current slot, current slot last
    function automatic res_t schedule_next();
        res_t        res;
        int unsigned prev;
        int unsigned base;
        int unsigned idx;
        bit          found;
        prev  = running_slot;
        base  = (prev < SLOTS) ? prev : 0;
        res   = '0;
        found = 1'b0;
        for (int k = 1; k <= SLOTS; k++) begin
            idx = (base + k) % SLOTS;
            if (!found && tcb_state[idx] == ST_RUNNABLE) begin
                found           = 1'b1;
                running_slot    = idx;
                tcb_state[idx]  = ST_RUNNING;
                tcb_slice[idx]  = tcb_prio[idx];
                res.slot        = 4'(idx);
                res.switched    = (idx != prev);
            end
        end
        if (!found) begin
            running_slot = SLOTS;
            res.idle     = 1'b1;
        end
        return res;
    endfunction

    function automatic res_t predict_word(sched_req_t r);
        res_t        res;
        int          p;
        int unsigned c;
        bit          done;
        res  = '0;
        c    = running_slot;
        done = 1'b0;
        case (r.func)
            FUNC_CREATE: begin
                res.status = STATUS_FULL;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && tcb_state[i] == ST_UNUSED) begin
                        done         = 1'b1;
                        tcb_state[i] = ST_RUNNABLE;
                        tcb_prio[i]  = prio_init;
                        tcb_slice[i] = prio_init;
                        tcb_ticks[i] = '0;
                        tcb_wake[i]  = '0;
                        res.status   = STATUS_DONE;
                        res.slot     = 4'(i);
                    end
                end
            end
            FUNC_WAKE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tcb_state[i] == ST_SLEEPING && r.now >= tcb_wake[i])
                        tcb_state[i] = ST_RUNNABLE;
                    if (tcb_state[i] == ST_WAIT_PIPE && i < 16 && r.mask[i])
                        tcb_state[i] = ST_RUNNABLE;
                end
            end
            FUNC_TICK: begin
                if (c < SLOTS && tcb_state[c] == ST_RUNNING) begin
                    tcb_ticks[c] = tcb_ticks[c] + 1;
                    if (tcb_slice[c] > 8'd1) begin
                        tcb_slice[c] = tcb_slice[c] - 8'd1;
                        res.slot     = 4'(c);
                        return res;
                    end
                    tcb_slice[c] = '0;
                    tcb_state[c] = ST_RUNNABLE;
                end
                res = schedule_next();
            end
            FUNC_SETPRI: begin
                if (int'(r.target) >= SLOTS || tcb_state[r.target] == ST_UNUSED) begin
                    res.status = STATUS_IGNORED;
                end else begin
                    // raise to the floor first, then cap; an inverted pair ends at the cap
                    p = r.new_pri;
                    if (p < int'(prio_floor)) p = int'(prio_floor);
                    if (p > int'(prio_ceil)) p = int'(prio_ceil);
                    tcb_prio[r.target] = 8'(p);
                    res.slot = r.target;
                end
            end
            FUNC_LEAVE: begin
                if (c >= SLOTS || tcb_state[c] != ST_RUNNING || r.leave > LEAVE_YIELD) begin
                    res.status = STATUS_IGNORED;
                end else begin
                    case (r.leave)
                        LEAVE_SLEEP: begin
                            tcb_state[c] = ST_SLEEPING;
                            tcb_wake[c]  = r.wake_at;
                        end
                        LEAVE_PIPE: tcb_state[c] = ST_WAIT_PIPE;
                        LEAVE_WAIT: tcb_state[c] = ST_WAITING;
                        LEAVE_ZOMB: tcb_state[c] = ST_ZOMBIE;
                        default:    tcb_state[c] = ST_RUNNABLE;
                    endcase
                    res = schedule_next();
                end
            end
            default: res.status = STATUS_IGNORED;
        endcase
        return res;
    endfunction

    function automatic sched_req_t make_request();
        sched_req_t  r;
        int unsigned pick;
        model_now += 64'($urandom_range(0, 12));
        pick = $urandom_range(0, 99);
        if (pick < 8)       r.func = FUNC_CREATE;
        else if (pick < 28) r.func = FUNC_WAKE;
        else if (pick < 60) r.func = FUNC_TICK;
        else if (pick < 72) r.func = FUNC_SETPRI;
        else if (pick < 95) r.func = FUNC_LEAVE;
        else                r.func = 3'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI));
        r.target = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 45)      r.new_pri = 16'($urandom_range(0, 300));
        else if (pick < 70) r.new_pri = 16'($urandom);
        else if (pick < 85) r.new_pri = 16'(-$urandom_range(1, 300));
        else begin
            case ($urandom_range(0, 3))
                0:       r.new_pri = 16'h8000;
                1:       r.new_pri = 16'h7fff;
                2:       r.new_pri = 16'h0000;
                default: r.new_pri = 16'hffff;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 85)      r.now = model_now;
        else if (pick < 93) r.now = {$urandom, $urandom};
        else                r.now = (pick < 97) ? ALL_ONES : '0;
        pick = $urandom_range(0, 99);
        if (pick < 80)      r.wake_at = model_now + 64'($urandom_range(0, 60));
        else if (pick < 90) r.wake_at = {$urandom, $urandom};
        else                r.wake_at = (pick < 95) ? ALL_ONES : '0;
        pick = $urandom_range(0, 99);
        if (pick < 50)      r.mask = 16'($urandom);
        else if (pick < 80) r.mask = 16'h0001 << $urandom_range(0, 15);
        else                r.mask = '0;
        // waiting and zombie slots never come back, so keep them rare
        pick = $urandom_range(0, 99);
        if (pick < 30)      r.leave = LEAVE_SLEEP;
        else if (pick < 55) r.leave = LEAVE_PIPE;
        else if (pick < 93) r.leave = LEAVE_YIELD;
        else if (pick < 95) r.leave = LEAVE_WAIT;
        else if (pick < 97) r.leave = LEAVE_ZOMB;
        else                r.leave = 3'($urandom_range(LEAVE_BAD_LO, LEAVE_BAD_HI));
        return r;
    endfunction

    // valid stays high on return; the caller drops it or sends again
    task automatic send_request(input sched_req_t r, output res_t want);
        int gap;
        if (src_no_gaps) gap = 0;
        else gap = draw_wait(src_run);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_func            <= r.func;
        s_target_slot     <= r.target;
        s_new_priority    <= r.new_pri;
        s_now_time        <= r.now;
        s_pipe_ready_mask <= r.mask;
        s_leave_state     <= r.leave;
        s_wake_at         <= r.wake_at;
        do @(posedge aclk); while (!s_ready);
        want = predict_word(r);
        expected_words.push_back(want);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // a wake scan is the slowest request
        repeat (SLOTS + 8) @(posedge aclk);
    endtask

    task automatic set_priorities(input logic [7:0] lo, hi, dflt);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRIO_MIN;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_PRIO_MAX;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_PRIO_DEF;
        cfg_wdata <= dflt;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        prio_floor = lo;
        prio_ceil  = hi;
        prio_init  = dflt;
    endtask

    task automatic apply(input logic [2:0] f, input logic [3:0] tgt,
                         input logic signed [15:0] pri, input logic [2:0] lv,
                         input logic [63:0] nw, input logic [63:0] wk,
                         input logic [15:0] msk);
        sched_req_t r;
        res_t       want;
        r.func    = f;
        r.target  = tgt;
        r.new_pri = pri;
        r.leave   = lv;
        r.now     = nw;
        r.wake_at = wk;
        r.mask    = msk;
        send_request(r, want);
    endtask

    task automatic test_directed();
        // nothing running yet: leave is rejected, tick reports idle
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_YIELD, '0, '0, '0);
        apply(FUNC_TICK, 4'd0, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_SETPRI, 4'd15, 16'sh7fff, LEAVE_SLEEP, '0, '0, '0);
        for (int f = FUNC_BAD_LO; f <= FUNC_BAD_HI; f++)
            apply(3'(f), 4'd15, 16'shffff, LEAVE_BAD_HI, ALL_ONES, ALL_ONES, 16'hffff);
        apply(FUNC_CREATE, 4'd15, 16'sh8000, LEAVE_BAD_HI, ALL_ONES, ALL_ONES, 16'hffff);
        apply(FUNC_CREATE, 4'd0, 16'sh7fff, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_CREATE, 4'd7, 16'sd0, LEAVE_PIPE, '0, '0, 16'h5a5a);
        apply(FUNC_SETPRI, 4'd0, 16'sh8000, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_SETPRI, 4'd1, 16'sh7fff, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_SETPRI, 4'd2, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        // no current task: search starts after slot 0
        apply(FUNC_TICK, 4'd0, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_TICK, 4'd0, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_SLEEP, '0, ALL_ONES, '0);
        // slice of one runs out on this tick
        apply(FUNC_TICK, 4'd0, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_PIPE, '0, '0, '0);
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_WAIT, '0, '0, '0);
        // deadline one short, then exactly met
        apply(FUNC_WAKE, 4'd0, 16'sd0, LEAVE_SLEEP, ALL_ONES - 64'd1, '0, 16'h0001);
        apply(FUNC_WAKE, 4'd0, 16'sd0, LEAVE_SLEEP, ALL_ONES, '0, 16'h0000);
        apply(FUNC_TICK, 4'd0, 16'sd0, LEAVE_SLEEP, '0, '0, '0);
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_ZOMB, '0, '0, '0);
        // lone yield picks itself again
        apply(FUNC_LEAVE, 4'd0, 16'sd0, LEAVE_YIELD, '0, '0, '0);
        for (int lv = LEAVE_BAD_LO; lv <= LEAVE_BAD_HI; lv++)
            apply(FUNC_LEAVE, 4'd0, 16'sd0, 3'(lv), '0, '0, '0);
        settle();
    endtask

    task automatic run_random_mix(input int words, input logic [7:0] lo, hi, dflt);
        sched_req_t r;
        res_t       want;
        int         taken;
        set_priorities(lo, hi, dflt);
        taken = 0;
        while (taken < words) begin
            r = make_request();
            send_request(r, want);
            taken++;
        end
        settle();
    endtask

    task automatic test_backpressure();
        sched_req_t r;
        res_t       want;
        set_priorities(8'd2, 8'd6, 8'd3);
        hold_cycles = 300;
        src_no_gaps = 1'b1;
        for (int k = 0; k < 40; k++) begin
            r = make_request();
            send_request(r, want);
        end
        src_no_gaps = 1'b0;
        settle();
    endtask

    initial begin : result_sink
        int   stall;
        res_t want;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = draw_wait(sink_run);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word with nothing pending: status %0d slot %0d",
                                          m_status, m_chosen_slot));
            end else begin
                want = expected_words.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                if (m_chosen_slot !== want.slot)
                    report_mismatch($sformatf("chosen_slot %0d, want %0d",
                                              m_chosen_slot, want.slot));
                if (m_switched !== want.switched)
                    report_mismatch($sformatf("switched %0b, want %0b",
                                              m_switched, want.switched));
                if (m_idle !== want.idle)
                    report_mismatch($sformatf("idle %0b, want %0b", m_idle, want.idle));
            end
        end
    end

    initial begin
        aresetn           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_PRIO_MIN;
        cfg_wdata         <= '0;
        s_valid           <= 1'b0;
        s_func            <= FUNC_CREATE;
        s_target_slot     <= '0;
        s_new_priority    <= '0;
        s_now_time        <= '0;
        s_pipe_ready_mask <= '0;
        s_leave_state     <= LEAVE_SLEEP;
        s_wake_at         <= '0;
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        run_random_mix(350, 8'd1, 8'd8, 8'd4);
        // floor above ceiling: every set-priority lands on the ceiling
        run_random_mix(150, 8'd255, 8'd1, 8'd255);
        run_random_mix(150, 8'd1, 8'd255, 8'd1);
        test_backpressure();
        run_random_mix(300, 8'd3, 8'd200, 8'd100);

        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> weighted_round_robin_scheduler.f
sv/wrr_pkg.sv
sv/wrr_ram.sv
sv/wrr_queue.sv
sv/wrr_front.sv
sv/wrr_back.sv
sv/weighted_round_robin_scheduler.sv
tb/sv/tb.sv
